### src/ptc_pkg.sv
// Shared widths, register indexes, limits and types for the trim compensation unit.
`timescale 1ns / 1ps

package ptc_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_TEMP_TRIM  = 3'd0;
    localparam logic [2:0] REG_PRESS_LOW  = 3'd1;
    localparam logic [2:0] REG_PRESS_HIGH = 3'd2;
    localparam logic [2:0] REG_MIXED_TRIM = 3'd3;
    localparam logic [2:0] REG_HUM_TRIM   = 3'd4;
    localparam logic [2:0] REG_HUM_PRES   = 3'd5;

    // Divider operand widths: numerator magnitude, divisor magnitude, quotient bits
    localparam int NUM_W = 63;
    localparam int DEN_W = 41;
    localparam int QUO_W = 37;

    // Saturation limits
    localparam logic signed [52:0] PRESS_NUM_LIM = 53'sd2951479051793528;
    localparam logic signed [41:0] HUM_PROD_LIM  = 42'sd1099511627776;
    localparam logic signed [51:0] HUM_MAX_Q22   = 52'sd419430400;
    localparam logic signed [34:0] PRESS_MAX     = 35'sd33554431;

    // Results that ride alongside the divider
    typedef struct packed {
        logic signed [15:0] temp_centi;
        logic [16:0]        hum_q22_10;
        logic               hum_valid;
        logic               neg;
        logic               dzero;
    } side_t;

endpackage

### src/ptc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with saturation detect.
`timescale 1ns / 1ps

module ptc_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_vld,
    input  logic [ptc_pkg::NUM_W-1:0]   num,
    input  logic [ptc_pkg::DEN_W-1:0]   den,
    input  ptc_pkg::side_t              side_in,
    output logic                        out_vld,
    output logic [ptc_pkg::QUO_W-1:0]   quo,
    output logic                        sat,
    output ptc_pkg::side_t              side_out
);

    localparam int NW  = ptc_pkg::NUM_W;
    localparam int DW  = ptc_pkg::DEN_W;
    localparam int QW  = ptc_pkg::QUO_W;
    localparam int CW  = DW + QW;

    logic [NW-1:0]      rem_reg  [0:QW];
    logic [QW-1:0]      quo_reg  [0:QW];
    logic [DW-1:0]      den_reg  [0:QW];
    logic               sat_reg  [0:QW];
    ptc_pkg::side_t     side_reg [0:QW];
    logic [QW:0]        vld_reg;

    logic               sat_next;

    // Flag quotients that would not fit in the quotient width
    assign sat_next = CW'(num) >= (CW'(den) << QW);

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[QW-1:0], in_vld};
        end
    end

    // Load the entry stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= num;
            quo_reg[0]  <= '0;
            den_reg[0]  <= den;
            sat_reg[0]  <= sat_next;
            side_reg[0] <= side_in;
        end
    end

    // One trial subtraction per stage, most significant quotient bit first
    for (genvar k = 1; k <= QW; k++)
    begin : g_stage
        localparam int SH = QW - k;
        logic [CW-1:0] shifted;
        logic          ge;

        assign shifted = CW'(den_reg[k-1]) << SH;
        assign ge      = CW'(rem_reg[k-1]) >= shifted;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]     <= ge ? rem_reg[k-1] - shifted[NW-1:0] : rem_reg[k-1];
                quo_reg[k]     <= quo_reg[k-1] | (QW'(ge) << SH);
                den_reg[k]     <= den_reg[k-1];
                sat_reg[k]     <= sat_reg[k-1];
                side_reg[k]    <= side_reg[k-1];
            end
        end
    end

    assign out_vld  = vld_reg[QW];
    assign quo      = quo_reg[QW];
    assign sat      = sat_reg[QW];
    assign side_out = side_reg[QW];

endmodule

### src/pressure_temp_humidity_compensation_unit.sv
// Top level: trim compensation of raw pressure, temperature and humidity samples.
// Throughput: one word per cycle; a new word may enter every cycle that the output is not stalled.
// The 37-stage quotient pipeline sets most of the latency.
// The whole pipeline holds only while a result waits and the output is stalled.
// Reset (async, active low) clears valid bits and loads the trim registers with zero,
// humidity channel present.
`timescale 1ns / 1ps

module pressure_temp_humidity_compensation_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // raw_press[19:0], raw_temp[39:20], raw_hum[55:40]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // temp_centi[15:0], press_q24_8[40:16],
                                        // hum_q22_10[57:41], zero fill
    output logic [1:0]  m_axis_tuser,   // press_valid[0], hum_valid[1]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int NW = ptc_pkg::NUM_W;
    localparam int DW = ptc_pkg::DEN_W;
    localparam int QW = ptc_pkg::QUO_W;

    typedef struct packed {
        logic [NW-1:0] num;
        logic [DW-1:0] den;
        logic          neg;
        logic          dzero;
    } pnd_t;

    // ---------------- configuration ----------------
    logic [47:0] temp_trim_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [55:0] mixed_trim_reg;
    logic [23:0] hum_trim_reg;
    logic        hum_present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_trim_reg   <= '0;
            press_low_reg   <= '0;
            press_high_reg  <= '0;
            mixed_trim_reg  <= '0;
            hum_trim_reg    <= '0;
            hum_present_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ptc_pkg::REG_TEMP_TRIM:  temp_trim_reg   <= cfg_data[47:0];
                ptc_pkg::REG_PRESS_LOW:  press_low_reg   <= cfg_data;
                ptc_pkg::REG_PRESS_HIGH: press_high_reg  <= cfg_data;
                ptc_pkg::REG_MIXED_TRIM: mixed_trim_reg  <= cfg_data[55:0];
                ptc_pkg::REG_HUM_TRIM:   hum_trim_reg    <= cfg_data[23:0];
                ptc_pkg::REG_HUM_PRES:   hum_present_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Trim fields
    logic [15:0]        t1;
    logic signed [15:0] t2, t3;
    logic signed [16:0] p1_s;
    logic [15:0]        p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9, h2;
    logic [7:0]         h1, h3;
    logic signed [7:0]  h6;
    logic signed [11:0] h4, h5;

    assign t1   = temp_trim_reg[15:0];
    assign t2   = $signed(temp_trim_reg[31:16]);
    assign t3   = $signed(temp_trim_reg[47:32]);
    assign p1   = press_low_reg[15:0];
    assign p1_s = $signed({1'b0, p1});
    assign p2   = $signed(press_low_reg[31:16]);
    assign p3   = $signed(press_low_reg[47:32]);
    assign p4   = $signed(press_low_reg[63:48]);
    assign p5   = $signed(press_high_reg[15:0]);
    assign p6   = $signed(press_high_reg[31:16]);
    assign p7   = $signed(press_high_reg[47:32]);
    assign p8   = $signed(press_high_reg[63:48]);
    assign p9   = $signed(mixed_trim_reg[15:0]);
    assign h2   = $signed(mixed_trim_reg[31:16]);
    assign h1   = mixed_trim_reg[39:32];
    assign h3   = mixed_trim_reg[47:40];
    assign h6   = $signed(mixed_trim_reg[55:48]);
    assign h4   = $signed(hum_trim_reg[11:0]);
    assign h5   = $signed(hum_trim_reg[23:12]);

    // ---------------- flow control ----------------
    logic        adv;
    logic [13:1] vld_reg;
    logic [4:1]  pv_reg;

    assign adv           = !pv_reg[4] || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[12:1], s_axis_tvalid};
        end
    end

    // ---------------- stage 1: temperature products ----------------
    logic [19:0]        rt_in;
    logic signed [17:0] dx_next;
    logic signed [16:0] dt_next;
    logic signed [33:0] dd_next;
    logic signed [33:0] s1_pa_reg;
    logic [32:0]        s1_dd_reg;
    logic [19:0]        rp1_reg, rp2_reg, rp3_reg, rp4_reg, rp5_reg, rp6_reg;
    logic [15:0]        rh1_reg, rh2_reg, rh3_reg, rh4_reg;

    assign rt_in   = s_axis_tdata[39:20];
    assign dx_next = $signed({1'b0, rt_in[19:3]}) - $signed({1'b0, t1, 1'b0});
    assign dt_next = $signed({1'b0, rt_in[19:4]}) - $signed({1'b0, t1});
    assign dd_next = dt_next * dt_next;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pa_reg <= dx_next * t2;
            s1_dd_reg <= dd_next[32:0];
            rp1_reg   <= s_axis_tdata[19:0];
            rh1_reg   <= s_axis_tdata[55:40];
        end
    end

    // ---------------- stages 2-3: fine temperature ----------------
    logic signed [22:0] s2_at_reg;
    logic signed [36:0] s2_bt_reg;
    logic signed [23:0] s3_tf_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_at_reg <= $signed(s1_pa_reg[33:11]);
            s2_bt_reg <= $signed({1'b0, s1_dd_reg[32:12]}) * t3;
            s3_tf_reg <= 24'(s2_at_reg) + 24'($signed(s2_bt_reg[36:14]));
            rp2_reg   <= rp1_reg;
            rp3_reg   <= rp2_reg;
            rh2_reg   <= rh1_reg;
            rh3_reg   <= rh2_reg;
        end
    end

    // ---------------- stage 4: temperature out, first pressure and humidity products ---
    logic signed [27:0] t5_next;
    logic signed [19:0] tsh_next;
    logic signed [15:0] temp_next;
    logic signed [23:0] pa_next, hv_next;

    logic signed [15:0] temp_line_reg [4:13];
    logic signed [47:0] s4_aa_reg;
    logic signed [39:0] s4_pap5_reg, s4_pap2_reg;
    logic signed [35:0] s4_h5v_reg;
    logic signed [31:0] s4_vh6_reg;
    logic signed [32:0] s4_vh3_reg;

    assign t5_next  = 28'(s3_tf_reg) * 28'sd5 + 28'sd128;
    assign tsh_next = $signed(t5_next[27:8]);
    assign pa_next  = s3_tf_reg - 24'sd128000;
    assign hv_next  = s3_tf_reg - 24'sd76800;

    // Saturate the temperature to 16 bits
    always_comb
    begin
        if (tsh_next > 20'sd32767)
            temp_next = 16'sh7fff;
        else if (tsh_next < -20'sd32768)
            temp_next = 16'sh8000;
        else
            temp_next = tsh_next[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            temp_line_reg[4] <= temp_next;
            s4_aa_reg        <= pa_next * pa_next;
            s4_pap5_reg      <= pa_next * p5;
            s4_pap2_reg      <= pa_next * p2;
            s4_h5v_reg       <= hv_next * h5;
            s4_vh6_reg       <= hv_next * h6;
            s4_vh3_reg       <= hv_next * $signed({1'b0, h3});
            rp4_reg          <= rp3_reg;
            rh4_reg          <= rh3_reg;
        end
    end

    // Carry the temperature to the divider entry
    for (genvar k = 5; k <= 13; k++)
    begin : g_temp_line
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                temp_line_reg[k] <= temp_line_reg[k-1];
            end
        end
    end

    // ---------------- stage 5 ----------------
    logic signed [37:0] f1s_next;
    logic signed [21:0] gx_next;
    logic signed [22:0] gy_next;
    logic signed [63:0] s5_aap6_reg, s5_aap3_reg;
    logic signed [39:0] s5_pap5_reg, s5_pap2_reg;
    logic signed [22:0] f1_line_reg [5:8];
    logic signed [44:0] s5_gp_reg;

    assign f1s_next = 38'($signed({1'b0, rh4_reg, 14'b0})) - 38'($signed({h4, 20'b0}))
                    - 38'(s4_h5v_reg) + 38'sd16384;
    assign gx_next  = $signed(s4_vh6_reg[31:10]);
    assign gy_next  = 23'($signed(s4_vh3_reg[32:11])) + 23'sd32768;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_aap6_reg    <= s4_aa_reg * p6;
            s5_aap3_reg    <= s4_aa_reg * p3;
            s5_pap5_reg    <= s4_pap5_reg;
            s5_pap2_reg    <= s4_pap2_reg;
            f1_line_reg[5] <= $signed(f1s_next[37:15]);
            s5_gp_reg      <= gx_next * gy_next;
            rp5_reg        <= rp4_reg;
        end
    end

    for (genvar k = 6; k <= 8; k++)
    begin : g_f1_line
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                f1_line_reg[k] <= f1_line_reg[k-1];
            end
        end
    end

    // ---------------- stage 6: pressure sums ----------------
    logic signed [64:0] s6_b_reg;
    logic signed [56:0] s6_a2_reg;
    logic signed [35:0] s6_g_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_b_reg  <= 65'(s5_aap6_reg) + 65'($signed({s5_pap5_reg, 17'b0}))
                       + 65'($signed({p4, 35'b0}));
            s6_a2_reg <= 57'($signed(s5_aap3_reg[63:8])) + 57'($signed({s5_pap2_reg, 12'b0}))
                       + 57'sh8000_0000_0000;
            s6_g_reg  <= 36'($signed(s5_gp_reg[44:10])) + 36'sd2097152;
            rp6_reg   <= rp5_reg;
        end
    end

    // ---------------- stage 7: numerator and divisor partial products ----------------
    logic [20:0]        pd_next;
    logic signed [65:0] n_next;
    logic signed [52:0] nc_next;
    logic signed [52:0] s7_n_reg;
    logic [43:0]        s7_lo_reg;
    logic signed [45:0] s7_hi_reg;
    logic signed [51:0] s7_gh2_reg;

    assign pd_next = 21'd1048576 - {1'b0, rp6_reg};
    assign n_next  = 66'($signed({1'b0, pd_next, 31'b0})) - 66'(s6_b_reg);

    // Hold the numerator within the trim sanity limit
    always_comb
    begin
        if (n_next > 66'(ptc_pkg::PRESS_NUM_LIM))
            nc_next = ptc_pkg::PRESS_NUM_LIM;
        else if (n_next < -66'(ptc_pkg::PRESS_NUM_LIM))
            nc_next = -ptc_pkg::PRESS_NUM_LIM;
        else
            nc_next = n_next[52:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_n_reg   <= nc_next;
            s7_lo_reg  <= s6_a2_reg[27:0] * p1;
            s7_hi_reg  <= $signed(s6_a2_reg[56:28]) * p1_s;
            s7_gh2_reg <= s6_g_reg * h2;
        end
    end

    // ---------------- stage 8: divisor and scaled numerator ----------------
    logic signed [73:0] dfull_next;
    logic signed [52:0] f2s_next;
    logic signed [40:0] s8_d_reg;
    logic signed [64:0] s8_n_reg;
    logic signed [38:0] s8_f2_reg;

    assign dfull_next = 74'($signed({s7_hi_reg, 28'b0})) + 74'($signed({1'b0, s7_lo_reg}));
    assign f2s_next   = 53'(s7_gh2_reg) + 53'sd8192;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8_d_reg  <= $signed(dfull_next[73:33]);
            s8_n_reg  <= 65'(s7_n_reg) * 65'sd3125;
            s8_f2_reg <= $signed(f2s_next[52:14]);
        end
    end

    // ---------------- stage 9: magnitudes and sign; humidity product ----------------
    logic signed [64:0] nneg_next;
    logic signed [40:0] dneg_next;
    pnd_t               pnd_next;
    pnd_t               pnd_line_reg [9:13];
    logic signed [61:0] s9_hp_reg;

    assign nneg_next = -s8_n_reg;
    assign dneg_next = -s8_d_reg;

    always_comb
    begin
        pnd_next.num   = s8_n_reg[64] ? nneg_next[NW-1:0] : s8_n_reg[NW-1:0];
        pnd_next.den   = s8_d_reg[40] ? dneg_next[DW-1:0] : s8_d_reg[DW-1:0];
        pnd_next.neg   = s8_n_reg[64] ^ s8_d_reg[40];
        pnd_next.dzero = (s8_d_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pnd_line_reg[9] <= pnd_next;
            s9_hp_reg       <= f1_line_reg[8] * s8_f2_reg;
        end
    end

    for (genvar k = 10; k <= 13; k++)
    begin : g_pnd_line
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pnd_line_reg[k] <= pnd_line_reg[k-1];
            end
        end
    end

    // ---------------- stages 10-13: humidity finish ----------------
    logic signed [41:0] hc_next;
    logic signed [41:0] hc10_reg, hc11_reg, hc12_reg;
    logic signed [26:0] s10_s_reg;
    logic signed [53:0] s11_ss_reg;
    logic [53:0]        s12_hh_reg;
    logic signed [51:0] hd_next;
    logic [16:0]        hum_next;
    logic [16:0]        s13_hum_reg;
    logic               s13_hv_reg;

    // Clamp the first humidity product
    always_comb
    begin
        if (s9_hp_reg > 62'(ptc_pkg::HUM_PROD_LIM))
            hc_next = ptc_pkg::HUM_PROD_LIM;
        else if (s9_hp_reg < -62'(ptc_pkg::HUM_PROD_LIM))
            hc_next = -ptc_pkg::HUM_PROD_LIM;
        else
            hc_next = s9_hp_reg[41:0];
    end

    assign hd_next = 52'(hc12_reg) - 52'($signed({1'b0, s12_hh_reg[53:4]}));

    // Clamp to 0..100 percent and drop to Q22.10
    always_comb
    begin
        if (hd_next < 52'sd0)
            hum_next = '0;
        else if (hd_next > ptc_pkg::HUM_MAX_Q22)
            hum_next = ptc_pkg::HUM_MAX_Q22[28:12];
        else
            hum_next = hd_next[28:12];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hc10_reg    <= hc_next;
            s10_s_reg   <= $signed(hc_next[41:15]);
            hc11_reg    <= hc10_reg;
            s11_ss_reg  <= s10_s_reg * s10_s_reg;
            hc12_reg    <= hc11_reg;
            s12_hh_reg  <= s11_ss_reg[52:7] * h1;
            s13_hum_reg <= hum_present_reg ? hum_next : 17'd0;
            s13_hv_reg  <= hum_present_reg;
        end
    end

    // ---------------- divider ----------------
    ptc_pkg::side_t side_in;
    ptc_pkg::side_t div_side;
    logic           div_vld;
    logic [QW-1:0]  div_quo;
    logic           div_sat;

    always_comb
    begin
        side_in.temp_centi = temp_line_reg[13];
        side_in.hum_q22_10 = s13_hum_reg;
        side_in.hum_valid  = s13_hv_reg;
        side_in.neg        = pnd_line_reg[13].neg;
        side_in.dzero      = pnd_line_reg[13].dzero;
    end

    ptc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (vld_reg[13]),
        .num      (pnd_line_reg[13].num),
        .den      (pnd_line_reg[13].den),
        .side_in  (side_in),
        .out_vld  (div_vld),
        .quo      (div_quo),
        .sat      (div_sat),
        .side_out (div_side)
    );

    // ---------------- post-divide pressure stages ----------------
    localparam logic [QW-1:0] Q_LIM = QW'(1) << (QW - 1);

    logic [QW-1:0]      qsel_next;
    logic signed [QW:0] qs_next;
    logic signed [QW:0] p1_p_reg, p2_p_reg, p3_p_reg;
    logic signed [49:0] p2_qq_reg;
    logic signed [53:0] p2_pe_reg;
    logic signed [65:0] c_full_next;
    logic signed [40:0] p3_c_reg;
    logic signed [34:0] p3_e_reg;
    logic signed [24:0] q13_next;
    logic signed [41:0] psum_next;
    logic signed [34:0] pfin_next;
    logic [24:0]        press_next;
    ptc_pkg::side_t     ps1_reg, ps2_reg, ps3_reg, ps4_reg;
    logic [24:0]        press_reg;

    assign qsel_next = (div_sat || div_quo > Q_LIM) ? Q_LIM : div_quo;
    assign qs_next   = div_side.neg ? -$signed({1'b0, qsel_next}) : $signed({1'b0, qsel_next});
    assign q13_next  = $signed(p1_p_reg[QW:13]);
    assign c_full_next = p2_qq_reg * p9;
    assign psum_next = 42'(p3_p_reg) + 42'(p3_c_reg) + 42'(p3_e_reg);
    assign pfin_next = 35'($signed(psum_next[41:8])) + 35'($signed({p7, 4'b0}));

    // Saturate the pressure and zero it on a zero divisor
    always_comb
    begin
        if (ps3_reg.dzero || pfin_next < 35'sd0)
            press_next = '0;
        else if (pfin_next > ptc_pkg::PRESS_MAX)
            press_next = ptc_pkg::PRESS_MAX[24:0];
        else
            press_next = pfin_next[24:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= '0;
        end
        else if (adv)
        begin
            pv_reg <= {pv_reg[3:1], div_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_p_reg  <= qs_next;
            ps1_reg   <= div_side;
            p2_p_reg  <= p1_p_reg;
            p2_qq_reg <= q13_next * q13_next;
            p2_pe_reg <= p1_p_reg * p8;
            ps2_reg   <= ps1_reg;
            p3_p_reg  <= p2_p_reg;
            p3_c_reg  <= $signed(c_full_next[65:25]);
            p3_e_reg  <= $signed(p2_pe_reg[53:19]);
            ps3_reg   <= ps2_reg;
            press_reg <= press_next;
            ps4_reg   <= ps3_reg;
        end
    end

    // Drive the result word
    assign m_axis_tvalid = pv_reg[4];
    assign m_axis_tdata  = {6'd0, ps4_reg.hum_q22_10, press_reg, ps4_reg.temp_centi};
    assign m_axis_tuser  = {ps4_reg.hum_valid, !ps4_reg.dzero};

`ifndef SYNTHESIS
    a_press_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[40:16] == 25'd0)
        else $error("pressure not zero on invalid divisor");

    a_hum_zero_when_absent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[57:41] == 17'd0)
        else $error("humidity not zero without humidity channel");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[57:41] <= 17'd102400)
        else $error("humidity above 100 percent");

    a_hum_flag_matches_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser[1] == hum_present_reg)
        else $error("humidity flag disagrees with channel setting");
`endif

endmodule

### tb/sv/tb_pressure_temp_humidity_compensation_unit.sv
// Testbench for the pressure, temperature and humidity trim compensation unit.
`timescale 1ns / 1ps

module tb_pressure_temp_humidity_compensation_unit;

    typedef struct packed {
        logic signed [15:0] temp_centi;
        logic [24:0]        press_q24_8;
        logic               press_valid;
        logic [16:0]        hum_q22_10;
        logic               hum_valid;
    } comp_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    // Trim shadow copies
    logic [47:0] temp_trim;
    logic [63:0] press_lo;
    logic [63:0] press_hi;
    logic [55:0] mixed_trim;
    logic [23:0] hum_trim;
    logic        hum_present;

    comp_word_t expected_words[$];
    int          errors;
    int          send_idle_pct;
    int          recv_idle_pct;

    pressure_temp_humidity_compensation_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint sat(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // floor(x * m / 2^33) without overflow
    function automatic longint scale_div(longint x, longint m);
        longint xh;
        longint xl;
        xh = x >>> 17;
        xl = x - xh * 131072;
        return ((xh * m) + ((xl * m) >>> 17)) >>> 16;
    endfunction

    function automatic comp_word_t compensate(logic [19:0] raw_p, logic [19:0] raw_t,
                                              logic [15:0] raw_h);
        comp_word_t r;
        longint rp, rt, rh;
        longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint h1, h2, h3, h4, h5, h6;
        longint a, b, d, tf, dv, n, p, q, c, e, v, f1, g, f2, s;
        rp = raw_p; rt = raw_t; rh = raw_h;
        t1 = temp_trim[15:0];
        t2 = $signed(temp_trim[31:16]);
        t3 = $signed(temp_trim[47:32]);
        p1 = press_lo[15:0];
        p2 = $signed(press_lo[31:16]);
        p3 = $signed(press_lo[47:32]);
        p4 = $signed(press_lo[63:48]);
        p5 = $signed(press_hi[15:0]);
        p6 = $signed(press_hi[31:16]);
        p7 = $signed(press_hi[47:32]);
        p8 = $signed(press_hi[63:48]);
        p9 = $signed(mixed_trim[15:0]);
        h2 = $signed(mixed_trim[31:16]);
        h1 = mixed_trim[39:32];
        h3 = mixed_trim[47:40];
        h6 = $signed(mixed_trim[55:48]);
        h4 = $signed(hum_trim[11:0]);
        h5 = $signed(hum_trim[23:12]);

        // Fine temperature
        a = (((rt >>> 3) - t1 * 2) * t2) >>> 11;
        d = (rt >>> 4) - t1;
        b = (((d * d) >>> 12) * t3) >>> 14;
        tf = a + b;
        r.temp_centi = 16'(sat((tf * 5 + 128) >>> 8, -32768, 32767));

        // Pressure
        a = tf - 128000;
        b = a * a * p6;
        b += a * p5 * 131072;
        b += p4 * 64'sd34359738368;
        a = ((a * a * p3) >>> 8) + a * p2 * 4096;
        a += 64'sd140737488355328;
        dv = scale_div(a, p1);
        r.press_q24_8 = '0;
        r.press_valid = 1'b0;
        if (dv != 0)
        begin
            n = (1048576 - rp) * 64'sd2147483648 - b;
            n = sat(n, -64'sd2951479051793528, 64'sd2951479051793528);
            p = (n * 3125) / dv;
            p = sat(p, -64'sd68719476736, 64'sd68719476736);
            q = p >>> 13;
            c = (p9 * q * q) >>> 25;
            e = (p8 * p) >>> 19;
            p = ((p + c + e) >>> 8) + p7 * 16;
            r.press_q24_8 = 25'(sat(p, 0, 33554431));
            r.press_valid = 1'b1;
        end

        // Humidity
        r.hum_q22_10 = '0;
        r.hum_valid = 1'b0;
        if (hum_present)
        begin
            v = tf - 76800;
            f1 = (rh * 16384 - h4 * 1048576 - h5 * v + 16384) >>> 15;
            g = ((((v * h6) >>> 10) * (((v * h3) >>> 11) + 32768)) >>> 10) + 2097152;
            f2 = (g * h2 + 8192) >>> 14;
            v = sat(f1 * f2, -64'sd1099511627776, 64'sd1099511627776);
            s = v >>> 15;
            v = v - ((((s * s) >>> 7) * h1) >>> 4);
            v = sat(v, 0, 419430400);
            r.hum_q22_10 = 17'(v >>> 12);
            r.hum_valid = 1'b1;
        end
        return r;
    endfunction

    // Write one trim register; only called while the unit is drained
    task automatic write_trim(logic [2:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            ptc_pkg::REG_TEMP_TRIM:  temp_trim = val[47:0];
            ptc_pkg::REG_PRESS_LOW:  press_lo = val;
            ptc_pkg::REG_PRESS_HIGH: press_hi = val;
            ptc_pkg::REG_MIXED_TRIM: mixed_trim = val[55:0];
            ptc_pkg::REG_HUM_TRIM:   hum_trim = val[23:0];
            ptc_pkg::REG_HUM_PRES:   hum_present = val[0];
            default: ;
        endcase
    endtask

    // Send one raw sample; caller is at a falling edge
    task automatic send_sample(logic [19:0] rp, logic [19:0] rt, logic [15:0] rh);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {rh, rt, rp};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        expected_words.push_back(compensate(rp, rt, rh));
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (expected_words.size() != 0) @(negedge clk);
        repeat (70) @(negedge clk);
    endtask

    // Typical datasheet-like trims
    task automatic load_nominal_trims();
        write_trim(ptc_pkg::REG_TEMP_TRIM, {16'hFC18, 16'd26435, 16'd27504});
        write_trim(ptc_pkg::REG_PRESS_LOW, {16'd2855, 16'hD0A5, 16'hD6D0, 16'd36477});
        write_trim(ptc_pkg::REG_PRESS_HIGH, {16'hFFC4, 16'd15500, 16'hFFF9, 16'd140});
        write_trim(ptc_pkg::REG_MIXED_TRIM, {8'd30, 8'd0, 8'd75, 16'd362, 16'd6000});
        write_trim(ptc_pkg::REG_HUM_TRIM, {12'd50, 12'd313});
        write_trim(ptc_pkg::REG_HUM_PRES, 64'd1);
    endtask

    task automatic test_directed();
        load_nominal_trims();
        send_sample(20'd0, 20'd0, 16'd0);
        send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_sample(20'd415148, 20'd519888, 16'd30000);
        send_sample(20'd0, 20'hFFFFF, 16'd0);
        send_sample(20'hFFFFF, 20'd0, 16'hFFFF);
        send_sample(20'h80000, 20'h80000, 16'h8000);
        drain();
        // No humidity channel: raw humidity ignored
        write_trim(ptc_pkg::REG_HUM_PRES, 64'd0);
        send_sample(20'd300000, 20'd500000, 16'hFFFF);
        send_sample(20'd300000, 20'd500000, 16'd0);
        drain();
        // Zero divisor: P1 cleared
        write_trim(ptc_pkg::REG_HUM_PRES, 64'd1);
        write_trim(ptc_pkg::REG_PRESS_LOW, 64'd0);
        send_sample(20'd400000, 20'd500000, 16'd20000);
        drain();
        // Absurd trims reach the saturation limits
        write_trim(ptc_pkg::REG_TEMP_TRIM, {16'h7FFF, 16'h7FFF, 16'hFFFF});
        write_trim(ptc_pkg::REG_PRESS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_trim(ptc_pkg::REG_PRESS_HIGH, 64'h8000_7FFF_8000_7FFF);
        write_trim(ptc_pkg::REG_MIXED_TRIM, 56'h7F_FF_FF_7FFF_8000);
        write_trim(ptc_pkg::REG_HUM_TRIM, 24'h7FF800);
        send_sample(20'd0, 20'hFFFFF, 16'hFFFF);
        send_sample(20'hFFFFF, 20'd0, 16'd0);
        send_sample(20'd12345, 20'h55555, 16'hAAAA);
        drain();
        write_trim(ptc_pkg::REG_TEMP_TRIM, {16'h8000, 16'h8000, 16'h0000});
        write_trim(ptc_pkg::REG_PRESS_LOW, 64'h8000_8000_8000_0001);
        write_trim(ptc_pkg::REG_PRESS_HIGH, 64'h8000_8000_8000_8000);
        write_trim(ptc_pkg::REG_MIXED_TRIM, 56'h80_00_00_8000_7FFF);
        write_trim(ptc_pkg::REG_HUM_TRIM, 24'h800800);
        send_sample(20'd0, 20'hFFFFF, 16'hFFFF);
        send_sample(20'hFFFFF, 20'd0, 16'd0);
        drain();
        // Index beyond the register list is dropped
        write_trim(3'd6, 64'hFFFF_FFFF_FFFF_FFFF);
        write_trim(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        send_sample(20'd5000, 20'd6000, 16'd7000);
        drain();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_sample(20'($urandom), 20'($urandom), 16'($urandom));
    endtask

    // Random phases: nominal trims, then fully random trims, under varied sender and receiver idle rates
    task automatic test_random_trims();
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 33; recv_idle_pct = 52; end
                1: begin send_idle_pct = 52; recv_idle_pct = 33; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int k = 0; k < 3; k++)
            begin
                if (k == 0)
                begin
                    load_nominal_trims();
                end
                else
                begin
                    write_trim(ptc_pkg::REG_TEMP_TRIM, {$urandom, $urandom});
                    write_trim(ptc_pkg::REG_PRESS_LOW, {$urandom, $urandom});
                    write_trim(ptc_pkg::REG_PRESS_HIGH, {$urandom, $urandom});
                    write_trim(ptc_pkg::REG_MIXED_TRIM, {$urandom, $urandom});
                    write_trim(ptc_pkg::REG_HUM_TRIM, {$urandom, $urandom});
                    write_trim(ptc_pkg::REG_HUM_PRES, 64'($urandom_range(1)));
                end
                test_random(50);
                drain();
            end
        end
    endtask

    // Compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        comp_word_t exp_w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (m_axis_tdata[15:0] !== exp_w.temp_centi)
                begin
                    $error("temp_centi exp %0d got %0d", exp_w.temp_centi,
                           $signed(m_axis_tdata[15:0]));
                    errors++;
                end
                if (m_axis_tdata[40:16] !== exp_w.press_q24_8)
                begin
                    $error("press_q24_8 exp %0d got %0d", exp_w.press_q24_8,
                           m_axis_tdata[40:16]);
                    errors++;
                end
                if (m_axis_tuser[0] !== exp_w.press_valid)
                begin
                    $error("press_valid exp %0d got %0d", exp_w.press_valid, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tdata[57:41] !== exp_w.hum_q22_10)
                begin
                    $error("hum_q22_10 exp %0d got %0d", exp_w.hum_q22_10,
                           m_axis_tdata[57:41]);
                    errors++;
                end
                if (m_axis_tuser[1] !== exp_w.hum_valid)
                begin
                    $error("hum_valid exp %0d got %0d", exp_w.hum_valid, m_axis_tuser[1]);
                    errors++;
                end
            end
        end
    end

    // Receiver stalls
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        #200000;
        $display("tb_pressure_temp_humidity_compensation_unit failed");
        $finish;
    end

    initial
    begin
        errors = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        temp_trim = '0;
        press_lo = '0;
        press_hi = '0;
        mixed_trim = '0;
        hum_trim = '0;
        hum_present = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // Reset trims: divisor zero, humidity present
        send_sample(20'd1000, 20'd2000, 16'd3000);
        drain();
        test_directed();
        test_random_trims();
        drain();
        if (errors == 0)
            $display("tb_pressure_temp_humidity_compensation_unit passed");
        else
            $display("tb_pressure_temp_humidity_compensation_unit failed");
        $finish;
    end
endmodule
